[hw/rtl/clr_pkg.sv]
// clr_pkg: widths, configuration register indexes, controller states and
// the command/status structs shared by the line rasterizer modules.
// no dependencies.
package clr_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_WINDOW = 64;

    localparam int DIFF_W = COORD_BITS + 1;       // endpoint differences a, b
    localparam int NUM_W  = 2 * COORD_BITS + 3;   // c and the per-step numerator
    localparam int REM_W  = NUM_W - 1;            // numerator magnitude
    localparam int MAG_W  = DIFF_W - 1;           // divisor magnitude
    localparam int WIN_W  = 7;                    // window registers
    localparam int PIX_W  = $clog2(MAX_WINDOW);   // pixel coordinates
    localparam int STEP_W = PIX_W + 1;            // walk position, up to the window size
    localparam int QB     = PIX_W + 1;            // quotient bits, top one flags overflow
    localparam int CNT_W  = $clog2(QB);
    localparam int COLOR_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF,
        ST_SETUP,
        ST_CTERM,
        ST_NUM,
        ST_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;       // capture the segment
        logic coef;       // a and b
        logic setup;      // major axis, walk bounds, a*x1
        logic cterm;      // c
        logic num;        // numerator at the first step
        logic div_load;   // start a division
        logic div_step;   // one quotient bit
        logic check;      // judge the pixel, advance the walk
        logic finish;     // flush the held pixel or the empty marker
    } t_cmd;

    typedef struct packed {
        logic run;        // walk has at least one step
        logic div_last;   // final quotient bit this cycle
        logic more;       // another step follows
    } t_stat;

endpackage

[hw/rtl/clr_ctrl.sv]
// clr_ctrl: sequencer for the line rasterizer, one segment at a time.
// depends on clr_pkg.
module clr_ctrl
    import clr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_COEF;
                end
            end
            ST_COEF:  n_state = ST_SETUP;
            ST_SETUP: n_state = ST_CTERM;
            ST_CTERM: begin
                n_state = i_stat.run ? ST_NUM : ST_FINISH;
            end
            ST_NUM:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.more ? ST_LOAD : ST_FINISH;
            end
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_COEF:   o_cmd.coef     = 1'b1;
            ST_SETUP:  o_cmd.setup    = 1'b1;
            ST_CTERM:  o_cmd.cterm    = 1'b1;
            ST_NUM:    o_cmd.num      = 1'b1;
            ST_LOAD:   o_cmd.div_load = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_CHECK:  o_cmd.check    = 1'b1;
            ST_FINISH: o_cmd.finish   = 1'b1;
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/clr_datapath.sv]
// clr_datapath: window registers, line coefficients, walk counter, bit-serial
// divider and the held-pixel / result registers of the line rasterizer.
// depends on clr_pkg.
module clr_datapath
    import clr_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [WIN_W-1:0]             i_cfg_data,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic signed [COORD_BITS-1:0] i_second_x,
    input  logic signed [COORD_BITS-1:0] i_second_y,
    input  logic [COLOR_W-1:0]           i_line_color,
    output logic                         o_valid,
    output logic [PIX_W-1:0]             o_pixel_x,
    output logic [PIX_W-1:0]             o_pixel_y,
    output logic [COLOR_W-1:0]           o_pixel_color,
    output logic                         o_visible,
    output logic                         o_last
);

    localparam logic signed [DIFF_W-1:0] ONE_D = DIFF_W'(1);

    // window registers
    logic [WIN_W-1:0] r_win_w;
    logic [WIN_W-1:0] r_win_h;

    // segment and coefficients
    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [COLOR_W-1:0]           r_color;
    logic signed [DIFF_W-1:0]     r_a, r_b;
    logic signed [NUM_W-1:0]      r_prod, r_c, r_num;
    logic                         r_xmaj;
    logic                         r_run;
    logic [STEP_W-1:0]            r_t, r_hi;

    // divider
    logic [REM_W-1:0] r_rem, r_dsh;
    logic [QB-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_qneg;

    // held pixel, released once the next one or the end is known
    logic             r_pend_v;
    logic [PIX_W-1:0] r_pend_x, r_pend_y;

    // result registers
    logic               r_o_valid;
    logic [PIX_W-1:0]   r_o_x, r_o_y;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_vis, r_o_last;

    logic [WIN_W-1:0]         w_lim, h_lim, major_lim, minor_lim;
    logic signed [DIFF_W-1:0] abs_a, abs_b;
    logic                     xmaj;
    logic signed [DIFF_W-1:0] mn_e, mx_e, lim_e, lo, hi;
    logic signed [NUM_W-1:0]  coef_k, coef_d, t_ext, num_abs;
    logic [MAG_W-1:0]         d_mag;
    logic                     ge;
    logic [PIX_W-1:0]         minor;
    logic                     vis;
    logic [PIX_W-1:0]         pix_x, pix_y;
    logic [STEP_W-1:0]        t_inc;

    // oversized register values act as the largest window
    assign w_lim = (r_win_w > WIN_MAX) ? WIN_MAX : r_win_w;
    assign h_lim = (r_win_h > WIN_MAX) ? WIN_MAX : r_win_h;

    assign abs_a = r_a[DIFF_W-1] ? -r_a : r_a;
    assign abs_b = r_b[DIFF_W-1] ? -r_b : r_b;
    assign xmaj  = abs_a < abs_b;
    assign major_lim = xmaj ? w_lim : h_lim;

    // walk bounds along the major axis, clipped to [1, lim)
    always_comb begin
        if (xmaj) begin
            mn_e = (r_x1 < r_x2) ? DIFF_W'(r_x1) : DIFF_W'(r_x2);
            mx_e = (r_x1 < r_x2) ? DIFF_W'(r_x2) : DIFF_W'(r_x1);
        end else begin
            mn_e = (r_y1 < r_y2) ? DIFF_W'(r_y1) : DIFF_W'(r_y2);
            mx_e = (r_y1 < r_y2) ? DIFF_W'(r_y2) : DIFF_W'(r_y1);
        end
        lim_e = DIFF_W'($signed({1'b0, major_lim}));
        lo    = (mn_e < ONE_D) ? ONE_D : mn_e;
        hi    = (mx_e > lim_e) ? lim_e : mx_e;
    end

    assign coef_k  = r_xmaj ? NUM_W'(r_a) : NUM_W'(r_b);
    assign coef_d  = r_xmaj ? NUM_W'(r_b) : NUM_W'(r_a);
    assign t_ext   = NUM_W'($signed({1'b0, r_t}));
    assign num_abs = r_num[NUM_W-1] ? -r_num : r_num;
    assign d_mag   = coef_d[NUM_W-1] ? MAG_W'(-coef_d) : MAG_W'(coef_d);
    assign ge      = r_rem >= r_dsh;

    // the top quotient bit means the minor coordinate is off the window
    assign minor     = r_quo[PIX_W-1:0];
    assign minor_lim = r_xmaj ? h_lim : w_lim;
    assign vis = !r_qneg && !r_quo[QB-1] && (minor != '0)
                 && ({1'b0, minor} < minor_lim);
    assign pix_x = r_xmaj ? r_t[PIX_W-1:0] : minor;
    assign pix_y = r_xmaj ? minor : r_t[PIX_W-1:0];
    assign t_inc = r_t + STEP_W'(1);

    assign o_stat.run      = r_run;
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.more     = t_inc < r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w <= WIN_RESET;
            r_win_h <= WIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_win_w <= i_cfg_data;
            end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                r_win_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1    <= i_first_x;
            r_y1    <= i_first_y;
            r_x2    <= i_second_x;
            r_y2    <= i_second_y;
            r_color <= i_line_color;
        end
        if (i_cmd.coef) begin
            r_a <= DIFF_W'(r_y2) - DIFF_W'(r_y1);
            r_b <= DIFF_W'(r_x1) - DIFF_W'(r_x2);
        end
        if (i_cmd.setup) begin
            r_xmaj <= xmaj;
            r_run  <= lo < hi;
            r_t    <= lo[STEP_W-1:0];
            r_hi   <= hi[STEP_W-1:0];
            r_prod <= NUM_W'(r_a) * NUM_W'(r_x1);
        end
        if (i_cmd.cterm) begin
            r_c <= -r_prod - NUM_W'(r_b) * NUM_W'(r_y1);
        end
        if (i_cmd.num) begin
            r_num <= -(coef_k * t_ext) - r_c;
        end
        if (i_cmd.div_load) begin
            r_rem  <= num_abs[REM_W-1:0];
            r_dsh  <= REM_W'({d_mag, {PIX_W{1'b0}}});
            r_quo  <= '0;
            r_cnt  <= CNT_W'(QB - 1);
            r_qneg <= r_num[NUM_W-1] ^ coef_d[NUM_W-1];
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[QB-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.check) begin
            r_t   <= t_inc;
            r_num <= r_num - coef_k;
            if (vis) begin
                r_pend_x <= pix_x;
                r_pend_y <= pix_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.load || i_cmd.finish) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.check && vis) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (i_cmd.check && vis && r_pend_v) || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !r_pend_v) begin
            // empty line marker
            r_o_x     <= '0;
            r_o_y     <= '0;
            r_o_color <= '0;
            r_o_vis   <= 1'b0;
            r_o_last  <= 1'b1;
        end else if (i_cmd.check || i_cmd.finish) begin
            r_o_x     <= r_pend_x;
            r_o_y     <= r_pend_y;
            r_o_color <= r_color;
            r_o_vis   <= 1'b1;
            r_o_last  <= i_cmd.finish;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_pixel_color = r_o_color;
    assign o_visible     = r_o_vis;
    assign o_last        = r_o_last;

endmodule

[hw/rtl/clipped_line_rasterizer.sv]
// clipped_line_rasterizer: top level, joins the sequencer and the datapath.
// depends on clr_pkg, clr_ctrl and clr_datapath.
//
// usage:
//   a segment (two signed endpoints and a color) transfers at a clock edge
//   with i_start high and o_busy low. o_busy stays high until the segment
//   is fully walked.
//   results come out one per o_valid pulse, each valid for a single cycle;
//   the receiver cannot stall, so it must take every pulse. o_last marks the
//   final result of a segment. a segment with nothing on screen gives one
//   result with o_visible low.
//   window registers are written through i_cfg_valid / o_cfg_ready (always
//   ready), index 0 width, index 1 height; write them only while idle.
//   sequence: coefficient, setup and c-term states, then (if there is a step)
//   the first numerator; then for each step along the major axis a divider
//   load, 7 quotient bits of the shared bit-serial divider and a pixel check;
//   then a flush. a segment has at most window size - 1 steps. the last
//   result is strobed in the first cycle with o_busy low, so the next
//   segment may be taken at the edge that ends it.
//   reset: synchronous, active low; window registers return to 64 and any
//   segment in flight is dropped.
module clipped_line_rasterizer
    import clr_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic signed [COORD_BITS-1:0] i_second_x,
    input  logic signed [COORD_BITS-1:0] i_second_y,
    input  logic [COLOR_W-1:0]           i_line_color,
    output logic                         o_valid,
    output logic [PIX_W-1:0]             o_pixel_x,
    output logic [PIX_W-1:0]             o_pixel_y,
    output logic [COLOR_W-1:0]           o_pixel_color,
    output logic                         o_visible,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [WIN_W-1:0]             i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    clr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    clr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_line_color  (i_line_color),
        .o_valid       (o_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_visible     (o_visible),
        .o_last        (o_last)
    );

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for the clipped line rasterizer.
// drives segments and window writes, predicts each pixel transfer and compares.
// depends on clr_pkg and clipped_line_rasterizer.
module tb_top;
    import clr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] x2;
        logic signed [COORD_BITS-1:0] y2;
        logic [COLOR_W-1:0]           color;
    } t_segment;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               visible;
        logic               last;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [COORD_BITS-1:0] i_first_x = '0;
    logic [COORD_BITS-1:0] i_first_y = '0;
    logic [COORD_BITS-1:0] i_second_x = '0;
    logic [COORD_BITS-1:0] i_second_y = '0;
    logic [COLOR_W-1:0]    i_line_color = '0;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_pixel_x;
    logic [PIX_W-1:0]      o_pixel_y;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_visible;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_IDX_WIDTH;
    logic [WIN_W-1:0]      i_cfg_data = '0;

    logic [WIN_W-1:0] model_win_w = WIN_RESET;
    logic [WIN_W-1:0] model_win_h = WIN_RESET;
    t_pixel           expected_pixels[$];
    int               mismatches = 0;
    int               cycle_count = 0;
    bit               gaps_enabled = 1'b1;

    clipped_line_rasterizer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_line_color (i_line_color),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_visible    (o_visible),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walk the clipped major axis and queue every visible pixel of the segment, or an empty marker if none
    function automatic void predict_pixels(input t_segment s);
        longint x1, y1, x2, y2, a, b, c, w, h, lo, hi, t, px, py;
        bit     xmajor;
        int     n;
        t_pixel p;
        x1 = longint'($signed(s.x1));
        y1 = longint'($signed(s.y1));
        x2 = longint'($signed(s.x2));
        y2 = longint'($signed(s.y2));
        w = (model_win_w > WIN_MAX) ? MAX_WINDOW : longint'(model_win_w);
        h = (model_win_h > WIN_MAX) ? MAX_WINDOW : longint'(model_win_h);
        a = y2 - y1;
        b = x1 - x2;
        c = -(a * x1) - (b * y1);
        xmajor = ((a < 0) ? -a : a) < ((b < 0) ? -b : b);
        n = 0;
        if (xmajor) begin
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            if (hi > w) hi = w;
        end else begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            if (hi > h) hi = h;
        end
        if (lo < 1) lo = 1;
        for (t = lo; t < hi && n < MAX_WINDOW - 1; t++) begin
            // signed longint division truncates toward zero
            if (xmajor) begin
                px = t;
                py = (-a * t - c) / b;
            end else begin
                py = t;
                px = (-b * t - c) / a;
            end
            if (px > 0 && py > 0 && px < w && py < h) begin
                p.x = PIX_W'(px);
                p.y = PIX_W'(py);
                p.color = s.color;
                p.visible = 1'b1;
                p.last = 1'b0;
                expected_pixels.push_back(p);
                n++;
            end
        end
        if (n == 0) begin
            p = '0;
            p.last = 1'b1;
            expected_pixels.push_back(p);
        end else begin
            expected_pixels[expected_pixels.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic t_segment make_segment(input int x1, input int y1, input int x2,
                                              input int y2, input logic [COLOR_W-1:0] color);
        t_segment s;
        s.x1 = COORD_BITS'(x1);
        s.y1 = COORD_BITS'(y1);
        s.x2 = COORD_BITS'(x2);
        s.y2 = COORD_BITS'(y2);
        s.color = color;
        return s;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_enabled || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord();
        return COORD_BITS'(int'($urandom_range(0, 76)) - 6);
    endfunction

    function automatic t_segment random_segment();
        t_segment s;
        int kind;
        kind = $urandom_range(0, 99);
        s.color = $urandom;
        s.x1 = near_coord();
        s.y1 = near_coord();
        s.x2 = near_coord();
        s.y2 = near_coord();
        if (kind >= 70 && kind < 85) begin
            // one endpoint random over the full range, the line may cross into view
            s.x2 = COORD_BITS'($urandom);
            s.y2 = COORD_BITS'($urandom);
        end else if (kind >= 85 && kind < 95) begin
            s.x1 = COORD_BITS'($urandom);
            s.y1 = COORD_BITS'($urandom);
            s.x2 = COORD_BITS'($urandom);
            s.y2 = COORD_BITS'($urandom);
        end else if (kind >= 95) begin
            s.x2 = s.x1;
            s.y2 = s.y1;
        end
        return s;
    endfunction

    function automatic logic [WIN_W-1:0] random_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 20) return WIN_W'($urandom_range(MAX_WINDOW + 1, 127));
        return WIN_W'($urandom_range(1, MAX_WINDOW));
    endfunction

    task automatic send_segment(input t_segment s);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_first_x <= s.x1;
        i_first_y <= s.y1;
        i_second_x <= s.x2;
        i_second_y <= s.y2;
        i_line_color <= s.color;
        do @(posedge i_clk); while (o_busy);
        predict_pixels(s);
    endtask

    // every segment gives at least one result, so an empty queue means idle
    task automatic drain();
        i_start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w, input logic [WIN_W-1:0] h);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_WIDTH;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_win_w = w;
        i_cfg_index <= CFG_IDX_HEIGHT;
        i_cfg_data <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_win_h = h;
        i_cfg_valid <= 1'b0;
    endtask

    // full 64x64 window out of reset: axes, extremes and the empty cases
    task automatic test_reset_window();
        send_segment(make_segment(10, 10, 10, 10, 32'h1234_5678));
        send_segment(make_segment(-10, 5, 100, 5, 32'hFFFF_FFFF));
        send_segment(make_segment(50, 20, 3, 20, 32'hA5A5_5A5A));
        send_segment(make_segment(7, -3, 7, 70, 32'h0000_0001));
        send_segment(make_segment(0, 0, 63, 63, 32'h8000_0000));
        send_segment(make_segment(63, 1, 1, 63, 32'h0F0F_0F0F));
        send_segment(make_segment(-5, 0, 80, 0, 32'h1111_1111));
        send_segment(make_segment(0, -5, 0, 80, 32'h2222_2222));
        send_segment(make_segment(-2048, -2048, 2047, 2047, 32'h0000_0000));
        send_segment(make_segment(2047, -2048, -2048, 2047, 32'hFFFF_FFFF));
        send_segment(make_segment(100, 100, 200, 300, 32'h3333_3333));
        send_segment(make_segment(-2048, -2048, -1, -5, 32'h4444_4444));
        send_segment(make_segment(-2048, 10, 2047, 40, 32'h5555_5555));
        send_segment(make_segment(20, -2048, 30, 2047, 32'h6666_6666));
        send_segment(make_segment(5, 5, 6, 5, 32'h7777_7777));
        send_segment(make_segment(60, 62, 2047, 63, 32'h8888_8888));
        send_segment(make_segment(2047, 2047, 2047, 2047, 32'h9999_9999));
    endtask

    // window extremes: zero, one, oversized and lopsided
    task automatic test_window_limits();
        logic [WIN_W-1:0] widths[7] = '{0, 64, 1, 127, 65, 2, 37};
        logic [WIN_W-1:0] heights[7] = '{64, 0, 1, 127, 2, 65, 50};
        foreach (widths[i]) begin
            write_window(widths[i], heights[i]);
            send_segment(make_segment(-100, -90, 200, 180, 32'hC0DE_0000 | i));
            repeat (5) send_segment(random_segment());
        end
    endtask

    task automatic test_random_segments();
        for (int phase = 0; phase < 5; phase++) begin
            write_window(random_window(), random_window());
            gaps_enabled = ($urandom_range(0, 3) != 0);
            repeat (90) send_segment(random_segment());
        end
        gaps_enabled = 1'b1;
    endtask

    // results cannot be stalled, so every strobe is compared at once
    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel transfer: x=%0d y=%0d visible=%0b",
                       o_pixel_x, o_pixel_y, o_visible);
                mismatches++;
            end else begin
                exp_pix = expected_pixels.pop_front();
                if (o_pixel_x !== exp_pix.x) begin
                    $error("pixel_x: expected %0d, got %0d", exp_pix.x, o_pixel_x);
                    mismatches++;
                end
                if (o_pixel_y !== exp_pix.y) begin
                    $error("pixel_y: expected %0d, got %0d", exp_pix.y, o_pixel_y);
                    mismatches++;
                end
                if (o_pixel_color !== exp_pix.color) begin
                    $error("pixel_color: expected %h, got %h", exp_pix.color, o_pixel_color);
                    mismatches++;
                end
                if (o_visible !== exp_pix.visible) begin
                    $error("visible: expected %0b, got %0b", exp_pix.visible, o_visible);
                    mismatches++;
                end
                if (o_last !== exp_pix.last) begin
                    $error("last: expected %0b, got %0b", exp_pix.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_window();
        test_window_limits();
        test_random_segments();
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/clr_pkg.sv
hw/rtl/clr_ctrl.sv
hw/rtl/clr_datapath.sv
hw/rtl/clipped_line_rasterizer.sv
tb/tb_top.sv
